>>> rtl/core/kst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kst_pkg
// Shared types and constants of the spanning-tree engine.
// ----------------------------------------------------------------------------
package kst_pkg;

    localparam int END_W   = 10;
    localparam int YEAR_W  = 16;
    localparam int PRICE_W = 32;
    localparam int KEY_W   = 32;
    localparam int CFG_W   = 11;
    localparam int MY_W    = 17;
    localparam int TP_W    = 48;

    localparam logic [CFG_W-1:0] VC_RESET  = 11'd1024;
    localparam logic [MY_W-1:0]  YEAR_NONE = '1;

    typedef struct packed {
        logic [END_W-1:0]   end_a;
        logic [END_W-1:0]   end_b;
        logic [YEAR_W-1:0]  edge_year;
        logic [PRICE_W-1:0] edge_price;
        logic               last_edge;
    } t_edge_item;

    typedef struct packed {
        logic signed [MY_W-1:0] max_year;
        logic [TP_W-1:0]        total_price;
    } t_result;

    typedef struct packed {
        logic init;
        logic link;
    } t_uf_cmd;

    typedef struct packed {
        logic done;
        logic linked;
    } t_uf_stat;

endpackage

>>> rtl/core/kst_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kst_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module kst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/kst_sorter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kst_sorter
// Bottom-up merge sort of {key, edge index} entries between two RAMs.
// ----------------------------------------------------------------------------
module kst_sorter #(
    parameter int MAX_EDGES = 4096
) (
    input  logic                                                 i_clk,
    input  logic                                                 i_rst_n,
    input  logic                                                 i_start,
    input  logic [$clog2(MAX_EDGES+1)-1:0]                       i_n,
    input  logic                                                 i_ld_we,
    input  logic [((MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1)-1:0] i_ld_addr,
    input  logic [kst_pkg::KEY_W+((MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1)-1:0] i_ld_data,
    input  logic [((MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1)-1:0] i_rd_addr,
    output logic [kst_pkg::KEY_W+((MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1)-1:0] o_rd_data,
    output logic                                                 o_busy,
    output logic                                                 o_done
);
    import kst_pkg::*;

    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int SW  = ECW + 2;
    localparam int EW  = KEY_W + EAW;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RUN  = 3'd1;
    localparam logic [2:0] S_RP   = 3'd2;
    localparam logic [2:0] S_CP   = 3'd3;
    localparam logic [2:0] S_CQ   = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;
    localparam logic [2:0] S_RQ   = 3'd6;

    logic [2:0]    r_state;
    logic          r_src;
    logic          r_init;
    logic          r_done;
    logic [SW-1:0] r_w, r_lo, r_mid, r_hi, r_p, r_q, r_k;
    logic [EW-1:0] r_hp, r_hq;

    logic [SW-1:0]  nx, lo_w, lo_2w, n_lo, n_w;
    logic           vp, vq, take_q, out_we, busy;
    logic [EAW-1:0] int_addr, raddr, waddr;
    logic [EW-1:0]  d0, d1, src_data, wdata;
    logic           we0, we1;

    assign nx     = SW'(i_n);
    assign lo_w   = r_lo + r_w;
    assign lo_2w  = r_lo + (r_w << 1);
    assign n_lo   = lo_2w;
    assign n_w    = r_w << 1;
    assign vp     = (r_p < r_mid);
    assign vq     = (r_q < r_hi);
    assign take_q = vq && (!vp || (r_hq[EW-1 -: KEY_W] < r_hp[EW-1 -: KEY_W]));
    assign busy   = (r_state != S_IDLE);
    assign out_we = (r_state == S_OUT) && (vp || vq);

    always_comb begin
        unique case (r_state)
            S_CP:    int_addr = r_q[EAW-1:0];
            S_RQ:    int_addr = r_q[EAW-1:0];
            default: int_addr = r_p[EAW-1:0];
        endcase
    end

    assign raddr    = busy ? int_addr : i_rd_addr;
    assign waddr    = busy ? r_k[EAW-1:0] : i_ld_addr;
    assign wdata    = busy ? (take_q ? r_hq : r_hp) : i_ld_data;
    assign we0      = busy ? (out_we && r_src) : i_ld_we;
    assign we1      = busy && out_we && !r_src;
    assign src_data = r_src ? d1 : d0;

    kst_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_buf0 (
        .i_clk   (i_clk),
        .i_we    (we0),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (d0)
    );

    kst_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_buf1 (
        .i_clk   (i_clk),
        .i_we    (we1),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (d1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_src   <= 1'b0;
            r_done  <= 1'b0;
            r_init  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_src <= 1'b0;
                        r_w   <= SW'(1);
                        r_lo  <= '0;
                        if (nx <= SW'(1)) begin
                            r_done <= 1'b1;
                        end else begin
                            r_state <= S_RUN;
                        end
                    end
                end
                S_RUN: begin
                    r_mid   <= (lo_w < nx) ? lo_w : nx;
                    r_hi    <= (lo_2w < nx) ? lo_2w : nx;
                    r_p     <= r_lo;
                    r_q     <= lo_w;
                    r_k     <= r_lo;
                    r_init  <= 1'b1;
                    r_state <= S_RP;
                end
                S_RP: begin
                    r_state <= S_CP;
                end
                S_CP: begin
                    r_hp <= src_data;
                    r_state <= r_init ? S_CQ : S_OUT;
                end
                S_CQ: begin
                    r_hq    <= src_data;
                    r_init  <= 1'b0;
                    r_state <= S_OUT;
                end
                S_RQ: begin
                    r_state <= S_CQ;
                end
                S_OUT: begin
                    if (!vp && !vq) begin
                        if (n_lo >= nx) begin
                            r_src <= !r_src;
                            r_w   <= n_w;
                            r_lo  <= '0;
                            if (n_w >= nx) begin
                                r_done  <= 1'b1;
                                r_state <= S_IDLE;
                            end else begin
                                r_state <= S_RUN;
                            end
                        end else begin
                            r_lo    <= n_lo;
                            r_state <= S_RUN;
                        end
                    end else begin
                        r_k <= r_k + SW'(1);
                        if (take_q) begin
                            r_q     <= r_q + SW'(1);
                            r_state <= S_RQ;
                        end else begin
                            r_p     <= r_p + SW'(1);
                            r_state <= S_RP;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rd_data = src_data;
    assign o_busy    = busy;
    assign o_done    = r_done;

endmodule

>>> rtl/core/kst_forest.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kst_forest
// Union-find forest in two RAMs: union by size and path compression.
// ----------------------------------------------------------------------------
module kst_forest #(
    parameter int MAX_VERTICES = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  kst_pkg::t_uf_cmd                      i_cmd,
    input  logic [$clog2(MAX_VERTICES+1)-1:0]     i_nv,
    input  logic [$clog2(MAX_VERTICES)-1:0]       i_a,
    input  logic [$clog2(MAX_VERTICES)-1:0]       i_b,
    output kst_pkg::t_uf_stat                     o_stat
);
    import kst_pkg::*;

    localparam int VW  = $clog2(MAX_VERTICES);
    localparam int NVW = $clog2(MAX_VERTICES + 1);

    localparam logic [3:0] F_IDLE = 4'd0;
    localparam logic [3:0] F_INIT = 4'd1;
    localparam logic [3:0] F_FR   = 4'd2;
    localparam logic [3:0] F_FW   = 4'd3;
    localparam logic [3:0] F_CR   = 4'd4;
    localparam logic [3:0] F_CW   = 4'd5;
    localparam logic [3:0] F_SA   = 4'd6;
    localparam logic [3:0] F_SB   = 4'd7;
    localparam logic [3:0] F_SC   = 4'd8;

    logic [3:0]     r_state;
    logic [NVW-1:0] r_i;
    logic [VW-1:0]  r_b, r_x, r_r, r_v, r_ra, r_rb;
    logic           r_phase;
    logic [NVW-1:0] r_sa;
    logic           r_done, r_linked;

    logic           p_we, s_we;
    logic [VW-1:0]  p_waddr, p_wdata, p_raddr, p_rdata, s_waddr, s_raddr;
    logic [NVW-1:0] s_wdata, s_rdata;
    logic           a_small;

    assign a_small = (r_sa < s_rdata);

    always_comb begin
        p_we    = 1'b0;
        p_waddr = r_v;
        p_wdata = r_r;
        p_raddr = r_r;
        s_we    = 1'b0;
        s_waddr = r_ra;
        s_wdata = r_sa + s_rdata;
        s_raddr = r_ra;
        unique case (r_state)
            F_INIT: begin
                p_we    = (r_i != i_nv);
                p_waddr = r_i[VW-1:0];
                p_wdata = r_i[VW-1:0];
                s_we    = (r_i != i_nv);
                s_waddr = r_i[VW-1:0];
                s_wdata = NVW'(1);
            end
            F_FW: begin
                p_raddr = p_rdata;
            end
            F_CR: begin
                p_raddr = r_v;
            end
            F_CW: begin
                p_raddr = p_rdata;
                p_we    = (p_rdata != r_r);
            end
            F_SB: begin
                s_raddr = r_rb;
            end
            F_SC: begin
                p_we    = 1'b1;
                p_waddr = a_small ? r_ra : r_rb;
                p_wdata = a_small ? r_rb : r_ra;
                s_we    = 1'b1;
                s_waddr = a_small ? r_rb : r_ra;
            end
            default: begin
            end
        endcase
    end

    kst_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_parent (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata)
    );

    kst_ram #(.WIDTH(NVW), .DEPTH(MAX_VERTICES)) u_size (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= F_IDLE;
            r_done   <= 1'b0;
            r_linked <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                F_IDLE: begin
                    if (i_cmd.init) begin
                        r_i     <= '0;
                        r_state <= F_INIT;
                    end else if (i_cmd.link) begin
                        r_b     <= i_b;
                        r_x     <= i_a;
                        r_r     <= i_a;
                        r_phase <= 1'b0;
                        r_state <= F_FR;
                    end
                end
                F_INIT: begin
                    if (r_i == i_nv) begin
                        r_done  <= 1'b1;
                        r_state <= F_IDLE;
                    end else begin
                        r_i <= r_i + NVW'(1);
                    end
                end
                F_FR: begin
                    r_state <= F_FW;
                end
                F_FW: begin
                    if (p_rdata == r_r) begin
                        r_v     <= r_x;
                        r_state <= F_CR;
                    end else begin
                        r_r <= p_rdata;
                    end
                end
                F_CR: begin
                    r_state <= F_CW;
                end
                F_CW: begin
                    if (p_rdata != r_r) begin
                        r_v <= p_rdata;
                    end else if (!r_phase) begin
                        r_ra    <= r_r;
                        r_phase <= 1'b1;
                        r_x     <= r_b;
                        r_r     <= r_b;
                        r_state <= F_FR;
                    end else if (r_ra == r_r) begin
                        r_done   <= 1'b1;
                        r_linked <= 1'b0;
                        r_state  <= F_IDLE;
                    end else begin
                        r_rb    <= r_r;
                        r_state <= F_SA;
                    end
                end
                F_SA: begin
                    r_state <= F_SB;
                end
                F_SB: begin
                    r_sa    <= s_rdata;
                    r_state <= F_SC;
                end
                F_SC: begin
                    r_done   <= 1'b1;
                    r_linked <= 1'b1;
                    r_state  <= F_IDLE;
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    assign o_stat.done   = r_done;
    assign o_stat.linked = r_linked;

endmodule

>>> rtl/core/kruskal_spanning_tree_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kruskal_spanning_tree_engine_top
// Stores a graph edge by edge, then runs Kruskal by year and by price.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                   Payload
//  edge     in         i_edge_valid / o_edge_stall t_edge_item
//  result   out        o_result_valid / i_result_stall t_result
//  cfg      in         i_cfg_valid / o_cfg_ready   vertex count, 11 bits
//
//  Edges are taken one per cycle while the engine is idle.
//  After the last edge the engine runs two passes; each initialises the forest
//  over the configured vertices, copies and sorts the stored edges, then walks the finds edge by edge,
//  paced by the single read port of the sort and forest RAMs.
//  Reset clears only control state; there is no clearing pass.
//  The result waits in its register under stall; the next graph may load.
// ----------------------------------------------------------------------------
module kruskal_spanning_tree_engine_top #(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_EDGES    = 4096
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_edge_valid,
    output logic                       o_edge_stall,
    input  kst_pkg::t_edge_item        i_edge,
    output logic                       o_result_valid,
    input  logic                       i_result_stall,
    output kst_pkg::t_result           o_result,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [kst_pkg::CFG_W-1:0]  i_cfg_data
);
    import kst_pkg::*;

    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int EW  = KEY_W + EAW;
    localparam int VW  = $clog2(MAX_VERTICES);
    localparam int NVW = $clog2(MAX_VERTICES + 1);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_FINIT = 4'd1;
    localparam logic [3:0] ST_FWAIT = 4'd2;
    localparam logic [3:0] ST_COPY  = 4'd3;
    localparam logic [3:0] ST_SORT  = 4'd4;
    localparam logic [3:0] ST_KRD   = 4'd5;
    localparam logic [3:0] ST_KIDX  = 4'd6;
    localparam logic [3:0] ST_KEND  = 4'd7;
    localparam logic [3:0] ST_KJOIN = 4'd8;
    localparam logic [3:0] ST_DONE  = 4'd9;

    logic [3:0]      r_state;
    logic [CFG_W-1:0] r_vc;
    logic [ECW-1:0]  r_cnt, r_i;
    logic            r_pass, r_any, r_cp_v;
    logic [EAW-1:0]  r_cp_addr;
    logic [TP_W-1:0] r_acc;
    logic [KEY_W-1:0] r_key;
    logic [MY_W-1:0] r_year_res;
    logic            r_res_valid;
    t_result         r_res;

    logic            accept, store, take, done_go;
    logic [NVW-1:0]  nv;
    logic            e_we, ld_we;
    logic [EAW-1:0]  e_waddr, e_raddr;
    logic [2*END_W-1:0] ends_rd;
    logic [YEAR_W-1:0]  year_rd;
    logic [PRICE_W-1:0] price_rd;
    logic [KEY_W-1:0]   cp_key;
    logic [EW-1:0]   ld_data, srt_rd;
    logic            sort_start, sort_busy, sort_done;
    logic [END_W-1:0] ea, eb;
    logic            ends_ok;
    t_uf_cmd         uf_cmd;
    t_uf_stat        uf_stat;
    logic [TP_W:0]   price_sum;

    assign accept  = i_edge_valid && !o_edge_stall;
    assign store   = accept && (32'(r_cnt) < MAX_EDGES);
    assign take    = r_res_valid && !i_result_stall;
    assign done_go = (r_state == ST_DONE) && (!r_res_valid || take);
    assign nv      = (32'(r_vc) > MAX_VERTICES) ? NVW'(MAX_VERTICES) : NVW'(r_vc);

    assign e_we    = store;
    assign e_waddr = r_cnt[EAW-1:0];
    assign e_raddr = (r_state == ST_KIDX) ? srt_rd[EAW-1:0] : r_i[EAW-1:0];

    kst_ram #(.WIDTH(2*END_W), .DEPTH(MAX_EDGES)) u_ends (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (e_waddr),
        .i_wdata ({i_edge.end_b, i_edge.end_a}),
        .i_raddr (e_raddr),
        .o_rdata (ends_rd)
    );

    kst_ram #(.WIDTH(YEAR_W), .DEPTH(MAX_EDGES)) u_years (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (e_waddr),
        .i_wdata (i_edge.edge_year),
        .i_raddr (e_raddr),
        .o_rdata (year_rd)
    );

    kst_ram #(.WIDTH(PRICE_W), .DEPTH(MAX_EDGES)) u_prices (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (e_waddr),
        .i_wdata (i_edge.edge_price),
        .i_raddr (e_raddr),
        .o_rdata (price_rd)
    );

    assign cp_key     = r_pass ? price_rd : KEY_W'(year_rd);
    assign ld_we      = (r_state == ST_COPY) && r_cp_v;
    assign ld_data    = {cp_key, r_cp_addr};
    assign sort_start = (r_state == ST_COPY) && (r_i == r_cnt);

    kst_sorter #(.MAX_EDGES(MAX_EDGES)) u_sorter (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (sort_start),
        .i_n       (r_cnt),
        .i_ld_we   (ld_we),
        .i_ld_addr (r_cp_addr),
        .i_ld_data (ld_data),
        .i_rd_addr (r_i[EAW-1:0]),
        .o_rd_data (srt_rd),
        .o_busy    (sort_busy),
        .o_done    (sort_done)
    );

    assign ea      = ends_rd[END_W-1:0];
    assign eb      = ends_rd[2*END_W-1:END_W];
    assign ends_ok = (32'(ea) < 32'(nv)) && (32'(eb) < 32'(nv));
    assign uf_cmd.init = (r_state == ST_FINIT);
    assign uf_cmd.link = (r_state == ST_KEND) && ends_ok;

    kst_forest #(.MAX_VERTICES(MAX_VERTICES)) u_forest (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (uf_cmd),
        .i_nv    (nv),
        .i_a     (VW'(ea)),
        .i_b     (VW'(eb)),
        .o_stat  (uf_stat)
    );

    assign price_sum = {1'b0, r_acc} + (TP_W + 1)'(r_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_vc        <= VC_RESET;
            r_cnt       <= '0;
            r_pass      <= 1'b0;
            r_cp_v      <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_vc <= i_cfg_data;
            end
            if (take) begin
                r_res_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (store) begin
                        r_cnt <= r_cnt + ECW'(1);
                    end
                    if (accept && i_edge.last_edge) begin
                        r_pass  <= 1'b0;
                        r_state <= ST_FINIT;
                    end
                end
                ST_FINIT: begin
                    r_acc   <= '0;
                    r_any   <= 1'b0;
                    r_state <= ST_FWAIT;
                end
                ST_FWAIT: begin
                    if (uf_stat.done) begin
                        r_i     <= '0;
                        r_cp_v  <= 1'b0;
                        r_state <= ST_COPY;
                    end
                end
                ST_COPY: begin
                    r_cp_addr <= r_i[EAW-1:0];
                    if (r_i == r_cnt) begin
                        r_cp_v  <= 1'b0;
                        r_state <= ST_SORT;
                    end else begin
                        r_cp_v <= 1'b1;
                        r_i    <= r_i + ECW'(1);
                    end
                end
                ST_SORT: begin
                    if (sort_done) begin
                        r_i     <= '0;
                        r_state <= ST_KRD;
                    end
                end
                ST_KRD: begin
                    if (r_i == r_cnt) begin
                        if (!r_pass) begin
                            r_year_res <= r_any ? {1'b0, r_acc[YEAR_W-1:0]} : YEAR_NONE;
                            r_pass     <= 1'b1;
                            r_state    <= ST_FINIT;
                        end else begin
                            r_state <= ST_DONE;
                        end
                    end else begin
                        r_state <= ST_KIDX;
                    end
                end
                ST_KIDX: begin
                    r_key   <= srt_rd[EW-1 -: KEY_W];
                    r_state <= ST_KEND;
                end
                ST_KEND: begin
                    if (ends_ok) begin
                        r_state <= ST_KJOIN;
                    end else begin
                        r_i     <= r_i + ECW'(1);
                        r_state <= ST_KRD;
                    end
                end
                ST_KJOIN: begin
                    if (uf_stat.done) begin
                        if (uf_stat.linked) begin
                            r_any <= 1'b1;
                            if (r_pass) begin
                                r_acc <= price_sum[TP_W] ? '1 : price_sum[TP_W-1:0];
                            end else if (!r_any || (r_key[YEAR_W-1:0] > r_acc[YEAR_W-1:0])) begin
                                r_acc <= TP_W'(r_key[YEAR_W-1:0]);
                            end
                        end
                        r_i     <= r_i + ECW'(1);
                        r_state <= ST_KRD;
                    end
                end
                ST_DONE: begin
                    if (done_go) begin
                        r_res_valid <= 1'b1;
                        r_cnt       <= '0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (done_go) begin
            r_res.max_year    <= r_year_res;
            r_res.total_price <= r_acc;
        end
    end

    assign o_edge_stall   = (r_state != ST_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_result_valid = r_res_valid;
    assign o_result       = r_res;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cnt) <= MAX_EDGES)
        else $error("edge count beyond edge store depth");

    a_sort_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sort_busy |-> (r_state == ST_SORT))
        else $error("sorter running outside the sort phase");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_result_valid) |-> $past(r_state == ST_DONE))
        else $error("result raised without a finished computation");

    a_link_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        uf_cmd.link |=> (r_state == ST_KJOIN))
        else $error("forest request not followed by a wait for it");

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the spanning-tree engine. Graphs are loaded edge
// by edge under random idling on both channels; on each last edge a local
// union-find model or a typed table row gives the largest year and the total
// price of both Kruskal passes; every result item is compared field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import kst_pkg::*;

    localparam int WATCHDOG = 1500000;
    localparam int EDGE_CAP = 4096;
    localparam int VTX_CAP  = 1024;

    typedef struct {
        int          vc;
        int          a;
        int          b;
        int          yr;
        longint      pr;
        bit          last;
        bit          typed;
        logic [16:0] my;
        logic [47:0] tp;
    } row_t;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_edge_valid = 1'b0;
    logic             o_edge_stall;
    t_edge_item       i_edge = '0;
    logic             o_result_valid;
    logic             i_result_stall = 1'b0;
    t_result          o_result;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_data = '0;

    t_result    tree_results_q[$];
    int         g_end_a[$];
    int         g_end_b[$];
    int         g_year[$];
    longint     g_price[$];
    int         uf_parent[VTX_CAP];
    int         uf_size[VTX_CAP];
    int         vertex_count = 1024;
    int         errors = 0;
    int         idle_cycles = 0;
    bit         hold_req = 1'b0;

    kruskal_spanning_tree_engine_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_edge_valid  (i_edge_valid),
        .o_edge_stall  (o_edge_stall),
        .i_edge        (i_edge),
        .o_result_valid(o_result_valid),
        .i_result_stall(i_result_stall),
        .o_result      (o_result),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic int find_root(int v);
        int r;
        int nx;
        r = v;
        while (uf_parent[r] != r) r = uf_parent[r];
        while (uf_parent[v] != r) begin
            nx = uf_parent[v];
            uf_parent[v] = r;
            v = nx;
        end
        return r;
    endfunction

    function automatic t_result close_graph();
        t_result     res;
        int          nv;
        int          ord[$];
        int          e;
        int          ra;
        int          rb;
        int          t;
        bit          any;
        int          best;
        logic [63:0] sum;
        nv = vertex_count > VTX_CAP ? VTX_CAP : vertex_count;
        for (int pass = 0; pass < 2; pass++) begin
            for (int i = 0; i < nv; i++) begin
                uf_parent[i] = i;
                uf_size[i] = 1;
            end
            ord.delete();
            for (int i = 0; i < g_end_a.size(); i++) ord = {ord, i};
            if (pass == 0) ord.sort() with (g_year[item]);
            else ord.sort() with (g_price[item]);
            any = 1'b0;
            best = 0;
            sum = '0;
            foreach (ord[k]) begin
                e = ord[k];
                if (g_end_a[e] >= nv || g_end_b[e] >= nv) continue;
                ra = find_root(g_end_a[e]);
                rb = find_root(g_end_b[e]);
                if (ra == rb) continue;
                if (uf_size[ra] < uf_size[rb]) begin
                    t = ra;
                    ra = rb;
                    rb = t;
                end
                uf_parent[rb] = ra;
                uf_size[ra] += uf_size[rb];
                if (pass == 0) begin
                    if (!any || g_year[e] > best) best = g_year[e];
                    any = 1'b1;
                end else begin
                    sum += g_price[e];
                    if (sum > 64'hFFFF_FFFF_FFFF) sum = 64'hFFFF_FFFF_FFFF;
                end
            end
            if (pass == 0) res.max_year = any ? MY_W'(best) : YEAR_NONE;
            else res.total_price = sum[TP_W-1:0];
        end
        g_end_a.delete();
        g_end_b.delete();
        g_year.delete();
        g_price.delete();
        return res;
    endfunction

    function automatic t_result load_edge(t_edge_item it);
        t_result none;
        none = '0;
        if (g_end_a.size() < EDGE_CAP) begin
            g_end_a = {g_end_a, int'(it.end_a)};
            g_end_b = {g_end_b, int'(it.end_b)};
            g_year = {g_year, int'(it.edge_year)};
            g_price = {g_price, longint'(it.edge_price)};
        end
        if (it.last_edge) return close_graph();
        return none;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 19);
        if (r < 10) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Called at a falling edge; returns at a falling edge after acceptance and a random idle gap.
    task automatic send_edge(t_edge_item it, bit typed, t_result typed_res);
        t_result pred;
        int      gap;
        i_edge_valid <= 1'b1;
        i_edge <= it;
        @(posedge i_clk);
        while (o_edge_stall) @(posedge i_clk);
        pred = load_edge(it);
        if (it.last_edge) tree_results_q = {tree_results_q, (typed ? typed_res : pred)};
        @(negedge i_clk);
        gap = gap_len();
        if (gap > 0) begin
            i_edge_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic set_vertex_count(int vc);
        i_edge_valid <= 1'b0;
        @(negedge i_clk);
        while (tree_results_q.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= CFG_W'(vc);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        vertex_count = vc;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic send_graph(int n, int year_span);
        t_edge_item it;
        int         nv;
        nv = vertex_count > VTX_CAP ? VTX_CAP : vertex_count;
        for (int i = 0; i < n; i++) begin
            if (nv == 0 || $urandom_range(0, 7) == 0) begin
                it.end_a = END_W'($urandom);
                it.end_b = END_W'($urandom);
            end else begin
                it.end_a = END_W'($urandom_range(0, nv - 1));
                it.end_b = END_W'($urandom_range(0, nv - 1));
            end
            it.edge_year = YEAR_W'(year_span > 0 ? $urandom_range(0, year_span) : $urandom);
            it.edge_price = $urandom_range(0, 3) == 0 ? PRICE_W'($urandom_range(0, 15))
                                                      : PRICE_W'($urandom);
            it.last_edge = (i == n - 1);
            send_edge(it, 1'b0, '0);
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (o_result_valid && !i_result_stall) begin
            if (tree_results_q.size() == 0) begin
                $error("unexpected result item: max_year %0d total_price %0d",
                       o_result.max_year, o_result.total_price);
                errors++;
            end else begin
                want = tree_results_q.pop_front();
                if (o_result.max_year !== want.max_year) begin
                    $error("max_year mismatch: expected %0d, actual %0d",
                           want.max_year, o_result.max_year);
                    errors++;
                end
                if (o_result.total_price !== want.total_price) begin
                    $error("total_price mismatch: expected %0d, actual %0d",
                           want.total_price, o_result.total_price);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_edge_valid && !o_edge_stall) || (o_result_valid && !i_result_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        int r;
        int len;
        @(posedge i_rst_n);
        forever begin
            len = 0;
            if (hold_req) begin
                i_result_stall <= 1'b1;
                repeat (2000) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                r = $urandom_range(0, 9);
                i_result_stall <= (r < 3);
                len = (r == 9) ? 60 : (r < 8 ? $urandom_range(0, 3) : $urandom_range(10, 40));
            end
            repeat (len + 1) @(negedge i_clk);
        end
    end

    initial begin
        row_t       rows[15];
        t_edge_item it;
        t_result    tr;
        int         vcs[6];
        int         sent;
        int         len;
        rows = '{
            '{1024, 0, 1, 5, 7, 1, 1, 17'd5, 48'd7},
            '{1024, 3, 3, 20, 30, 1, 1, 17'h1FFFF, 48'd0},
            '{1024, 1023, 0, 65535, 64'hFFFFFFFF, 1, 1, 17'd65535, 48'hFFFFFFFF},
            '{1024, 0, 1, 0, 0, 0, 0, 17'd0, 48'd0},
            '{1024, 1, 0, 100, 100, 1, 1, 17'd0, 48'd0},
            '{2, 1, 2, 4, 4, 1, 1, 17'h1FFFF, 48'd0},
            '{2, 0, 1, 4, 4, 1, 1, 17'd4, 48'd4},
            '{0, 0, 0, 1, 1, 1, 1, 17'h1FFFF, 48'd0},
            '{0, 0, 1, 1, 1, 1, 1, 17'h1FFFF, 48'd0},
            '{2047, 1023, 1022, 9, 9, 1, 1, 17'd9, 48'd9},
            '{1, 0, 0, 3, 3, 1, 1, 17'h1FFFF, 48'd0},
            '{3, 0, 1, 10, 50, 0, 0, 17'd0, 48'd0},
            '{3, 1, 2, 20, 5, 0, 0, 17'd0, 48'd0},
            '{3, 0, 2, 15, 6, 1, 0, 17'd0, 48'd0},
            '{1024, 512, 511, 32768, 64'h80000000, 1, 1, 17'd32768, 48'h80000000}
        };
        vcs = '{1024, 2047, 0, 1, 2, 1000};
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (rows[k]) begin
            if (rows[k].vc != vertex_count) set_vertex_count(rows[k].vc);
            it.end_a = END_W'(rows[k].a);
            it.end_b = END_W'(rows[k].b);
            it.edge_year = YEAR_W'(rows[k].yr);
            it.edge_price = PRICE_W'(rows[k].pr);
            it.last_edge = rows[k].last;
            tr.max_year = rows[k].my;
            tr.total_price = rows[k].tp;
            send_edge(it, rows[k].typed, tr);
        end

        sent = 0;
        for (int ph = 0; sent < 600; ph++) begin
            if (ph < 6) set_vertex_count(vcs[ph]);
            else set_vertex_count($urandom_range(0, 3) == 0 ? $urandom_range(0, 2047)
                                                          : $urandom_range(2, 40));
            if (ph == 3) set_vertex_count(64);
            if (ph == 4) hold_req = 1'b1;
            for (int g = 0; g < 6; g++) begin
                len = $urandom_range(0, 9) == 0 ? $urandom_range(30, 60) : $urandom_range(1, 14);
                send_graph(len, $urandom_range(0, 1) ? 7 : 0);
                sent += len;
            end
        end
        i_edge_valid <= 1'b0;

        while (tree_results_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/kst_pkg.sv
rtl/core/kst_ram.sv
rtl/core/kst_sorter.sv
rtl/core/kst_forest.sv
rtl/core/kruskal_spanning_tree_engine_top.sv
tb/sv/tb_top.sv
